@@ sv/quad_corner_validator_defines.svh @@
// ----------------------------------------------------------------------------
// Quad corner validator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef QUAD_CORNER_VALIDATOR_DEFINES_SVH
`define QUAD_CORNER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled at the rising edge of clk
`define QCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is delayed by the dly argument
`define QCV_ASSERT_DLY(lbl, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

@@ sv/qcv_pkg.sv @@
// ----------------------------------------------------------------------------
// Quad corner validator package
// Widths, codes, reset values and the orientation test table of the block.
// ----------------------------------------------------------------------------
package qcv_pkg;

	// Fixed point format of the corner coordinates
	localparam int COORD_FRAC_BITS = 4;
	localparam int COORD_W         = 20;
	localparam int SIZE_W          = 14;
	localparam int MIN_AREA_W      = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int STATUS_W        = 3;

	// Frame limit in fixed point and the signed compare width that holds both
	localparam int LIM_W = SIZE_W + COORD_FRAC_BITS;
	localparam int CMP_W = ((COORD_W > LIM_W) ? COORD_W : LIM_W) + 1;

	// Orientation test widths
	localparam int DIFF_W  = COORD_W + 1;
	localparam int TPROD_W = 2 * DIFF_W;
	localparam int TURN_W  = TPROD_W + 1;

	// Shoelace widths
	localparam int SPROD_W = 2 * COORD_W;
	localparam int TERM_W  = SPROD_W + 1;
	localparam int PAIR_W  = TERM_W + 1;
	localparam int AREA_W  = PAIR_W + 1;

	localparam int N_CORNERS  = 4;
	localparam int N_TURNS    = 8;
	localparam int PIPE_DEPTH = 6;

	// Register reset values
	localparam logic [SIZE_W-1:0]     CAL_WIDTH_RST  = SIZE_W'(1280);
	localparam logic [SIZE_W-1:0]     CAL_HEIGHT_RST = SIZE_W'(1024);
	localparam logic [MIN_AREA_W-1:0] MIN_AREA_RST   = MIN_AREA_W'(2048);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} corner_t;

	typedef logic [1:0] corner_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_SIZE    = 3'd1,
		ST_OUTSIDE = 3'd2,
		ST_CROSS   = 3'd3,
		ST_DEGEN   = 3'd4,
		ST_ORDER   = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_WIDTH  = 2'd0,
		CFG_CAL_HEIGHT = 2'd1,
		CFG_MIN_AREA   = 2'd2
	} cfg_idx_t;

	// Outcome of one orientation test: sign of the turn, and turn zero with
	// the test corner inside the box of the edge
	typedef struct packed {
		logic pos;
		logic neg;
		logic touch;
	} turn_flags_t;

	// Corners (a, b, c) of each orientation test, corners numbered
	// bottom-left, top-left, top-right, bottom-right.
	// Tests 0..3: edge BL-TL against edge TR-BR.
	// Tests 4..7: edge TL-TR against edge BR-BL.
	localparam corner_idx_t TURN_A [N_TURNS] =
		'{2'd0, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd3};
	localparam corner_idx_t TURN_B [N_TURNS] =
		'{2'd1, 2'd1, 2'd3, 2'd3, 2'd2, 2'd2, 2'd0, 2'd0};
	localparam corner_idx_t TURN_C [N_TURNS] =
		'{2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};

endpackage

@@ sv/qcv_turn.sv @@
// ----------------------------------------------------------------------------
// Quad corner validator orientation test
// Three-stage pipeline giving the sign of the turn a->b->c and whether c
// lies on segment a-b (zero turn inside the bounding box of a and b).
// ----------------------------------------------------------------------------
module qcv_turn (
	input  logic                  clk,
	input  qcv_pkg::corner_t      a,
	input  qcv_pkg::corner_t      b,
	input  qcv_pkg::corner_t      c,
	output qcv_pkg::turn_flags_t  flags
);
	import qcv_pkg::*;

	logic signed [DIFF_W-1:0]  dbx_s2, dby_s2, dcx_s2, dcy_s2;
	logic                      box_s2;
	logic signed [TPROD_W-1:0] pa_s3, pb_s3;
	logic                      box_s3;
	logic signed [TURN_W-1:0]  turn_c;
	turn_flags_t               flags_s4;
	logic                      box_c;

	// Test c against the bounding box of a and b, limits inclusive
	assign box_c = (c.x >= a.x || c.x >= b.x) && (c.x <= a.x || c.x <= b.x) &&
	               (c.y >= a.y || c.y >= b.y) && (c.y <= a.y || c.y <= b.y);

	// Take the edge vectors
	always_ff @(posedge clk) begin
		dbx_s2 <= DIFF_W'(b.x) - DIFF_W'(a.x);
		dby_s2 <= DIFF_W'(b.y) - DIFF_W'(a.y);
		dcx_s2 <= DIFF_W'(c.x) - DIFF_W'(a.x);
		dcy_s2 <= DIFF_W'(c.y) - DIFF_W'(a.y);
		box_s2 <= box_c;
	end

	// Form the two cross products
	always_ff @(posedge clk) begin
		pa_s3  <= dbx_s2 * dcy_s2;
		pb_s3  <= dby_s2 * dcx_s2;
		box_s3 <= box_s2;
	end

	assign turn_c = TURN_W'(pa_s3) - TURN_W'(pb_s3);

	// Reduce the turn to its sign and the on-segment flag
	always_ff @(posedge clk) begin
		flags_s4.pos   <= !turn_c[TURN_W-1] && (turn_c != '0);
		flags_s4.neg   <= turn_c[TURN_W-1];
		flags_s4.touch <= (turn_c == '0) && box_s3;
	end

	assign flags = flags_s4;

endmodule

@@ sv/quad_corner_validator.sv @@
// ----------------------------------------------------------------------------
// Quad corner validator
// Geometry prefilter for one detected quadrilateral: frame size, corners
// inside the frame, crossing edges, area threshold and winding.
// ----------------------------------------------------------------------------
// The block takes one quadrilateral in every clock cycle: busy is always low,
// so a word is accepted at each edge with start high. Each word gives one
// result: done is high for exactly one cycle, with status and dbl_area valid
// in that cycle only. The block is a six-stage pipeline (input checks, edge
// vectors, products, product differences, area sum and crossing logic,
// status). The receiver cannot hold results off, and none is needed: results
// leave in order, one per cycle at most. dbl_area is the shoelace sum in
// units of 1/256 square pixel and is given for every status. Write the
// configuration registers only while no result is still in the pipeline.
// ----------------------------------------------------------------------------
module quad_corner_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	output logic                                done,
	input  logic                                cfg_we,
	input  logic [qcv_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [qcv_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic [qcv_pkg::SIZE_W-1:0]          frame_width,
	input  logic [qcv_pkg::SIZE_W-1:0]          frame_height,
	input  logic signed [qcv_pkg::COORD_W-1:0]  bl_x,
	input  logic signed [qcv_pkg::COORD_W-1:0]  bl_y,
	input  logic signed [qcv_pkg::COORD_W-1:0]  tl_x,
	input  logic signed [qcv_pkg::COORD_W-1:0]  tl_y,
	input  logic signed [qcv_pkg::COORD_W-1:0]  tr_x,
	input  logic signed [qcv_pkg::COORD_W-1:0]  tr_y,
	input  logic signed [qcv_pkg::COORD_W-1:0]  br_x,
	input  logic signed [qcv_pkg::COORD_W-1:0]  br_y,
	output qcv_pkg::status_t                    status,
	output logic signed [qcv_pkg::AREA_W-1:0]   dbl_area
);
	import qcv_pkg::*;

	`include "quad_corner_validator_defines.svh"

	function automatic logic straddle(turn_flags_t p, turn_flags_t q);
		return (p.pos && q.neg) || (p.neg && q.pos);
	endfunction

	// Configuration registers
	logic [SIZE_W-1:0]     cal_width_q, cal_height_q;
	logic [MIN_AREA_W-1:0] min_area_q;

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// Payload
	corner_t                  corner_in [N_CORNERS];
	corner_t                  corner_s1 [N_CORNERS];
	logic [N_CORNERS-1:0]     out_c;
	logic [LIM_W-1:0]         wlim, hlim;
	logic signed [CMP_W-1:0]  wlim_c, hlim_c;
	logic                     size_bad_c;
	status_t                  early_s1, early_s2, early_s3, early_s4, early_s5;
	logic signed [SPROD_W-1:0] spa_s2 [N_CORNERS];
	logic signed [SPROD_W-1:0] spb_s2 [N_CORNERS];
	logic signed [TERM_W-1:0]  term_s3 [N_CORNERS];
	logic signed [PAIR_W-1:0]  pair_s4 [2];
	logic signed [AREA_W-1:0]  area_s5, area_s6;
	turn_flags_t              turn_flags [N_TURNS];
	logic                     cross_c, cross_s5;
	logic [AREA_W-1:0]        mag_c;
	status_t                  status_c, status_s6;

	// Accept a word in every cycle
	assign busy = 1'b0;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_width_q  <= CAL_WIDTH_RST;
			cal_height_q <= CAL_HEIGHT_RST;
			min_area_q   <= MIN_AREA_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CAL_WIDTH:  cal_width_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_CAL_HEIGHT: cal_height_q <= cfg_wdata[SIZE_W-1:0];
				CFG_MIN_AREA:   min_area_q   <= cfg_wdata[MIN_AREA_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign corner_in[0] = '{x: bl_x, y: bl_y};
	assign corner_in[1] = '{x: tl_x, y: tl_y};
	assign corner_in[2] = '{x: tr_x, y: tr_y};
	assign corner_in[3] = '{x: br_x, y: br_y};

	// Frame limits in fixed point
	assign wlim   = LIM_W'(frame_width) << COORD_FRAC_BITS;
	assign hlim   = LIM_W'(frame_height) << COORD_FRAC_BITS;
	assign wlim_c = $signed(CMP_W'(wlim));
	assign hlim_c = $signed(CMP_W'(hlim));

	assign size_bad_c = (frame_width != cal_width_q) || (frame_height != cal_height_q);

	// Flag corners outside the frame
	for (genvar i = 0; i < N_CORNERS; i++) begin : g_inside
		logic signed [CMP_W-1:0] cx, cy;
		assign cx = CMP_W'(corner_in[i].x);
		assign cy = CMP_W'(corner_in[i].y);
		assign out_c[i] = (cx < 0) || (cy < 0) || (cx >= wlim_c) || (cy >= hlim_c);
	end

	// Stage 1: register corners and the frame checks
	always_ff @(posedge clk) begin
		corner_s1 <= corner_in;
		if (size_bad_c) begin
			early_s1 <= ST_SIZE;
		end else if (out_c != '0) begin
			early_s1 <= ST_OUTSIDE;
		end else begin
			early_s1 <= ST_OK;
		end
	end

	// Orientation tests for both pairs of opposite edges
	for (genvar t = 0; t < N_TURNS; t++) begin : g_turn
		qcv_turn u_turn (
			.clk   (clk),
			.a     (corner_s1[TURN_A[t]]),
			.b     (corner_s1[TURN_B[t]]),
			.c     (corner_s1[TURN_C[t]]),
			.flags (turn_flags[t])
		);
	end

	// Shoelace: products, terms and pairwise sums
	for (genvar i = 0; i < N_CORNERS; i++) begin : g_shoe
		always_ff @(posedge clk) begin
			spa_s2[i]  <= corner_s1[i].x * corner_s1[(i + 1) % N_CORNERS].y;
			spb_s2[i]  <= corner_s1[i].y * corner_s1[(i + 1) % N_CORNERS].x;
			term_s3[i] <= TERM_W'(spa_s2[i]) - TERM_W'(spb_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		pair_s4[0] <= PAIR_W'(term_s3[0]) + PAIR_W'(term_s3[1]);
		pair_s4[1] <= PAIR_W'(term_s3[2]) + PAIR_W'(term_s3[3]);
		early_s2   <= early_s1;
		early_s3   <= early_s2;
		early_s4   <= early_s3;
	end

	// Combine orientation tests into the crossing verdict
	assign cross_c =
		(straddle(turn_flags[0], turn_flags[1]) && straddle(turn_flags[2], turn_flags[3])) ||
		turn_flags[0].touch || turn_flags[1].touch ||
		turn_flags[2].touch || turn_flags[3].touch ||
		(straddle(turn_flags[4], turn_flags[5]) && straddle(turn_flags[6], turn_flags[7])) ||
		turn_flags[4].touch || turn_flags[5].touch ||
		turn_flags[6].touch || turn_flags[7].touch;

	// Stage 5: total area and crossing
	always_ff @(posedge clk) begin
		area_s5  <= AREA_W'(pair_s4[0]) + AREA_W'(pair_s4[1]);
		cross_s5 <= cross_c;
		early_s5 <= early_s4;
	end

	// Pick the first failing check
	assign mag_c = area_s5[AREA_W-1] ? AREA_W'(-area_s5) : AREA_W'(area_s5);

	always_comb begin
		if (early_s5 != ST_OK) begin
			status_c = early_s5;
		end else if (cross_s5) begin
			status_c = ST_CROSS;
		end else if (mag_c < AREA_W'(min_area_q)) begin
			status_c = ST_DEGEN;
		end else if (area_s5[AREA_W-1]) begin
			status_c = ST_ORDER;
		end else begin
			status_c = ST_OK;
		end
	end

	// Stage 6: result word
	always_ff @(posedge clk) begin
		status_s6 <= status_c;
		area_s6   <= area_s5;
	end

	assign done     = v_s6;
	assign status   = status_s6;
	assign dbl_area = area_s6;

	`QCV_ASSERT_DLY(a_latency, start && !busy, PIPE_DEPTH, done, "accepted word gave no result")
	`QCV_ASSERT_IMP(a_no_spurious, done, $past(start, PIPE_DEPTH), "result without a word")
	`QCV_ASSERT_IMP(a_ok_area, done && status == ST_OK, !dbl_area[AREA_W-1], "ok with negative area")
	`QCV_ASSERT_IMP(a_order_area, done && status == ST_ORDER, dbl_area[AREA_W-1], "wrong order with nonnegative area")

endmodule
